// ===== sv/slot_value_store_lowest_match_defines.svh =====
// Assertion macros for the slot value store.
`ifndef SLOT_VALUE_STORE_LOWEST_MATCH_DEFINES_SVH
`define SLOT_VALUE_STORE_LOWEST_MATCH_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SVLM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svlm: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SVLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svlm: next-cycle check failed");

`endif

// ===== sv/svlm_pkg.sv =====
package svlm_pkg;

  localparam int SLOTS      = 64;
  localparam int VALUE_BITS = 32;
  localparam int SLOT_W     = 6;
  localparam int ADDR_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS) + 1;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;

endpackage

// ===== sv/slot_value_store_lowest_match.sv =====
// Slot value store with lowest-slot lookup.
// Input channel (in_valid/in_ready): one word carries in_mode, in_slot and
// in_value. A write word (mode 0) stores in_value into in_slot, marks the slot
// occupied and gives no result. A lookup word (mode 1) searches for in_value
// and gives one result word on the output channel (out_valid/out_ready):
// out_found and out_lowest_slot, the lowest occupied slot holding the value
// (0 when not found).
// Writes may follow back to back. A lookup walks the slots one per cycle
// through the single read port of the value memory and one shared 32-bit
// comparator; it stops at the first hit. Each slot is read into a data
// register and compared with the key; the result then waits in the hold
// state for the output register; in_ready is low during the walk and hold.
// The output register holds a finished result while the receiver stalls;
// writes are still taken meanwhile, and a following lookup waits at its end
// until the output register is free.
// Reset (rst_n low, synchronous) clears all occupied marks, so every slot is
// empty, and drops any pending result. No clearing pass is needed.
`include "slot_value_store_lowest_match_defines.svh"

module slot_value_store_lowest_match
  import svlm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [5:0]        in_slot,
  input  logic [31:0]       in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [5:0]        out_lowest_slot
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  value_t         mem [SLOTS];
  logic [SLOTS-1:0] valid_r;

  logic [1:0]     state_r, state_nxt;
  cnt_t           cnt_r, cnt_nxt;
  addr_t          cmp_idx_r, cmp_idx_nxt;
  logic           cmp_vld_r, cmp_vld_nxt;
  value_t         key_r;
  value_t         rd_data_r;
  logic           vld_data_r;
  logic           res_found_r, res_found_nxt;
  addr_t          res_slot_r, res_slot_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_found_r;
  logic [5:0]     out_slot_r;

  logic           in_acc;
  logic           wr_en;
  addr_t          wr_addr;
  addr_t          rd_addr;
  logic           hit;
  logic           out_load;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign wr_en    = in_acc && (in_mode == MODE_WRITE) && (CNT_W'(in_slot) < CNT_W'(SLOTS));
  assign wr_addr  = ADDR_W'(in_slot);
  assign rd_addr  = cnt_r[ADDR_W-1:0];
  assign hit      = cmp_vld_r && vld_data_r && (rd_data_r == key_r);
  assign out_load = (state_r == ST_HOLD) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= VALUE_BITS'(in_value);
    end
    rd_data_r  <= mem[rd_addr];
    vld_data_r <= valid_r[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_vld_nxt   = 1'b0;
    res_found_nxt = res_found_r;
    res_slot_nxt  = res_slot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_mode == MODE_LOOKUP)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r < CNT_W'(SLOTS)) begin
          cmp_idx_nxt = rd_addr;
          cmp_vld_nxt = 1'b1;
          cnt_nxt     = cnt_r + CNT_W'(1);
        end
        if (hit) begin
          res_found_nxt = 1'b1;
          res_slot_nxt  = cmp_idx_r;
          cmp_vld_nxt   = 1'b0;
          state_nxt     = ST_HOLD;
        end else if (cmp_vld_r && (cmp_idx_r == ADDR_W'(SLOTS - 1))) begin
          res_found_nxt = 1'b0;
          res_slot_nxt  = '0;
          cmp_vld_nxt   = 1'b0;
          state_nxt     = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r   <= cmp_idx_nxt;
    res_found_r <= res_found_nxt;
    res_slot_r  <= res_slot_nxt;
    if (in_acc) begin
      key_r <= VALUE_BITS'(in_value);
    end
    if (out_load) begin
      out_found_r <= res_found_r;
      out_slot_r  <= res_found_r ? 6'(res_slot_r) : 6'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_lowest_slot = out_slot_r;

  `SVLM_ASSERT_NEXT(a_lookup_starts, in_acc && (in_mode == MODE_LOOKUP),
                    (state_r == ST_SCAN) && (cnt_r == '0))
  `SVLM_ASSERT_NEXT(a_write_marks, wr_en, valid_r[$past(wr_addr)])
  `SVLM_ASSERT_NEXT(a_hold_stall, (state_r == ST_HOLD) && out_valid_r && !out_ready,
                    (state_r == ST_HOLD) && out_valid_r)
  `SVLM_ASSERT_SAME(a_miss_zero, out_valid_r && !out_found_r, out_slot_r == 6'd0)

endmodule

// ===== test/lowest_match_checker.sv =====
module lowest_match_checker
  import svlm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_mode,
  input  logic [SLOT_W-1:0] in_slot,
  input  value_t            in_value,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_found,
  input  logic [SLOT_W-1:0] out_lowest_slot,
  output int                mismatch_count,
  output int                lookups_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } match_t;

  value_t slot_value [SLOTS];
  logic   slot_taken [SLOTS];
  match_t expected_matches [$];

  function automatic match_t find_lowest_slot(value_t key);
    match_t hit;
    hit = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_taken[i] && slot_value[i] == key) begin
        hit.found = 1'b1;
        hit.slot  = SLOT_W'(i);
      end
    end
    return hit;
  endfunction

  initial begin
    mismatch_count    = 0;
    lookups_in_flight = 0;
  end

  always @(posedge clk) begin
    match_t want;
    if (!rst_n) begin
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      expected_matches.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_matches.size() == 0) begin
          $error("result word with no lookup outstanding: found %0d lowest_slot %0d",
                 out_found, out_lowest_slot);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = expected_matches.pop_front();
          if (out_found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_found);
            mismatch_count = mismatch_count + 1;
          end
          if (out_lowest_slot !== want.slot) begin
            $error("lowest_slot: expected %0d, actual %0d", want.slot, out_lowest_slot);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_mode == MODE_WRITE) begin
          if (in_slot < SLOTS) begin
            slot_value[in_slot] = in_value;
            slot_taken[in_slot] = 1'b1;
          end
        end else begin
          expected_matches.insert(expected_matches.size(), find_lowest_slot(in_value));
        end
      end
    end
    lookups_in_flight = expected_matches.size();
  end

endmodule

// ===== test/slot_value_store_lowest_match_test.sv =====
module slot_value_store_lowest_match_test
  import svlm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_WORDS = 1850;
  localparam int POOL_SIZE    = 12;
  localparam int SIDE_SEND    = 0;
  localparam int SIDE_RECV    = 1;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_mode;
  logic [SLOT_W-1:0] in_slot;
  value_t            in_value;
  logic              out_valid;
  logic              out_ready;
  logic              out_found;
  logic [SLOT_W-1:0] out_lowest_slot;

  int mismatch_count;
  int lookups_in_flight;
  int cycle_count;
  int quiet_left [2];

  slot_value_store_lowest_match u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_slot         (in_slot),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_lowest_slot (out_lowest_slot)
  );

  lowest_match_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_slot           (in_slot),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_lowest_slot   (out_lowest_slot),
    .mismatch_count    (mismatch_count),
    .lookups_in_flight (lookups_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    quiet_left[SIDE_SEND] = 0;
    quiet_left[SIDE_RECV] = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int draw_wait(int side);
    if (quiet_left[side] > 0) begin
      quiet_left[side] = quiet_left[side] - 1;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet_left[side] = $urandom_range(8, 60);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic send_word(logic mode, logic [SLOT_W-1:0] slot, value_t val);
    int gap;
    gap = draw_wait(SIDE_SEND);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_slot  <= slot;
    in_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  // stall the result channel per word
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait(SIDE_RECV);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    value_t value_pool [POOL_SIZE];
    value_t key;
    logic   is_lookup;
    int     pick;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_mode  = MODE_WRITE;
    in_slot  = '0;
    in_value = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table
    send_word(MODE_LOOKUP, 6'd63, 32'h0000_0000);
    send_word(MODE_LOOKUP, 6'd0,  32'hFFFF_FFFF);
    // extremes of slot and value
    send_word(MODE_WRITE,  6'd63, 32'hFFFF_FFFF);
    send_word(MODE_LOOKUP, 6'd5,  32'hFFFF_FFFF);
    send_word(MODE_WRITE,  6'd0,  32'h0000_0000);
    send_word(MODE_LOOKUP, 6'd42, 32'h0000_0000);
    // same value in several slots: lowest wins
    send_word(MODE_WRITE,  6'd40, 32'h5A5A_A5A5);
    send_word(MODE_WRITE,  6'd12, 32'h5A5A_A5A5);
    send_word(MODE_WRITE,  6'd33, 32'h5A5A_A5A5);
    send_word(MODE_LOOKUP, 6'd63, 32'h5A5A_A5A5);
    // overwrite drops the old value
    send_word(MODE_WRITE,  6'd12, 32'h1234_5678);
    send_word(MODE_LOOKUP, 6'd0,  32'h5A5A_A5A5);
    send_word(MODE_LOOKUP, 6'd21, 32'h1234_5678);
    send_word(MODE_WRITE,  6'd0,  32'hFFFF_FFFF);
    send_word(MODE_LOOKUP, 6'd1,  32'hFFFF_FFFF);
    send_word(MODE_LOOKUP, 6'd2,  32'h0000_0000);
    send_word(MODE_WRITE,  6'd1,  32'h8000_0000);
    send_word(MODE_LOOKUP, 6'd30, 32'h8000_0000);
    send_word(MODE_LOOKUP, 6'd31, 32'h0000_0001);
    send_word(MODE_WRITE,  6'd62, 32'h0000_0001);
    send_word(MODE_LOOKUP, 6'd62, 32'h0000_0001);

    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    // bias keys toward a small pool so lookups hit and values repeat
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      is_lookup = 1'($urandom_range(0, 1));
      pick      = $urandom_range(0, 9);
      key       = (pick < 7) ? value_pool[$urandom_range(0, POOL_SIZE - 1)] : value_t'($urandom);
      send_word(is_lookup ? MODE_LOOKUP : MODE_WRITE, SLOT_W'($urandom_range(0, SLOTS - 1)),
                key);
      if (!is_lookup && pick >= 7) value_pool[$urandom_range(2, POOL_SIZE - 1)] = key;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (lookups_in_flight != 0) @(negedge clk);
    repeat (SLOTS + 8) @(negedge clk);

    if (mismatch_count == 0 && lookups_in_flight == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== slot_value_store_lowest_match.f =====
+incdir+sv
sv/svlm_pkg.sv
sv/slot_value_store_lowest_match.sv
test/lowest_match_checker.sv
test/slot_value_store_lowest_match_test.sv
